### sv/b58enc_pkg.sv
package b58enc_pkg;

    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 6;
    localparam int FULL_BYTES  = 8;
    localparam int FULL_CHARS  = 11;
    localparam int BLOCK_W     = FULL_BYTES * BYTE_W;
    localparam int COUNT_W     = 4;
    localparam int STEP_W      = 3;
    localparam int RADIX       = 58;

    // partial remainder and next byte form one 14-bit dividend per step
    localparam int DIVIDEND_W  = DIGIT_W + BYTE_W;
    // floor(x / 58) == (x * RECIP) >> RECIP_SHIFT for every x below 58 * 256
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP = 15'd18079;
    localparam int PROD_W      = DIVIDEND_W + RECIP_W;

    localparam logic [RADIX*8-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] idx;
        logic [8:0]         pos;
        idx = 6'(RADIX - 1) - d;
        pos = {idx, 3'b000};
        if (d >= 6'(RADIX)) begin
            char_of = ALPHABET[(RADIX-1)*8 +: CHAR_W];
        end else begin
            char_of = ALPHABET[pos +: CHAR_W];
        end
    endfunction

    function automatic logic [COUNT_W-1:0] ndig_of(input logic [COUNT_W-1:0] n);
        case (n)
            4'd1:    ndig_of = 4'd2;
            4'd2:    ndig_of = 4'd3;
            4'd3:    ndig_of = 4'd5;
            4'd4:    ndig_of = 4'd6;
            4'd5:    ndig_of = 4'd7;
            4'd6:    ndig_of = 4'd9;
            4'd7:    ndig_of = 4'd10;
            4'd8:    ndig_of = 4'd11;
            default: ndig_of = 4'd0;
        endcase
    endfunction

endpackage

### sv/base58_block_encoder_unit.sv
// base58 block encoder
// input channel: one raw byte per request on i_in_byte, i_final_byte high on
// the last byte of the stream. bytes gather big-endian into a 64-bit block.
// a block closes on its eighth byte or on a final byte; then o_in_stall stays
// high until the last character of the block has been loaded for output.
// output channel: one alphabet character per request on o_out_char, most
// significant digit first. o_block_end marks the last character of a block,
// o_stream_end additionally the last character of the final block.
// a block of n bytes gives 2,3,5,6,7,9,10,11 characters for n = 1..8.
// a closing byte starts the shared divide-by-58 step, which divides the
// block once per character (one byte of the block per cycle), then gives
// one character per cycle while the receiver does not stall. the next
// byte is taken once the block is out; other bytes do not stall the input.
// a stall only holds the output register; the sequencer waits for it.
// reset clears the gathered block, the sequencer and the output valid.
module base58_block_encoder_unit
    import b58enc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_final_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_block_end,
    output logic              o_stream_end
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [BLOCK_W-1:0]   r_block, n_block;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [BLOCK_W-1:0]   r_val, n_val;
    logic [DIGIT_W-1:0]   r_rem, n_rem;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [COUNT_W-1:0]   r_dig_idx, n_dig_idx;
    logic [COUNT_W-1:0]   r_ndig, n_ndig;
    logic [COUNT_W-1:0]   r_emit_idx, n_emit_idx;
    logic                 r_fin, n_fin;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_block_end, n_block_end;
    logic                 r_stream_end, n_stream_end;

    logic [DIGIT_W-1:0]   r_buf [0:FULL_CHARS-1];

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_load;
    logic [COUNT_W-1:0]   w_n;
    logic [BLOCK_W-1:0]   w_new_block;
    logic [BYTE_W-1:0]    w_quot;
    logic [DIGIT_W-1:0]   w_rem;
    logic                 w_buf_we;
    logic                 w_last;

    b58enc_div_step u_div (
        .i_rem  (r_rem),
        .i_byte (r_val[BLOCK_W-1 -: BYTE_W]),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_load       = (r_state == S_EMIT) && w_out_free;
    assign w_n          = r_count + 4'd1;
    assign w_new_block  = {r_block[BLOCK_W-BYTE_W-1:0], i_in_byte};
    assign w_buf_we     = (r_state == S_DIV) && (r_step == STEP_W'(FULL_BYTES - 1));
    assign w_last       = (r_emit_idx == r_ndig - 4'd1);

    always_comb begin
        n_state      = r_state;
        n_block      = r_block;
        n_count      = r_count;
        n_val        = r_val;
        n_rem        = r_rem;
        n_step       = r_step;
        n_dig_idx    = r_dig_idx;
        n_ndig       = r_ndig;
        n_emit_idx   = r_emit_idx;
        n_fin        = r_fin;
        n_out_valid  = r_out_valid && i_out_stall;
        n_block_end  = r_block_end;
        n_stream_end = r_stream_end;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_block = w_new_block;
                    n_count = w_n;
                    if (w_n == COUNT_W'(FULL_BYTES) || i_final_byte) begin
                        n_state   = S_DIV;
                        n_val     = w_new_block;
                        n_rem     = '0;
                        n_step    = '0;
                        n_ndig    = ndig_of(w_n);
                        n_dig_idx = ndig_of(w_n) - 4'd1;
                        n_fin     = i_final_byte;
                    end
                end
            end
            S_DIV: begin
                n_val  = {r_val[BLOCK_W-BYTE_W-1:0], w_quot};
                n_rem  = w_rem;
                n_step = r_step + 3'd1;
                if (w_buf_we) begin
                    n_rem = '0;
                    if (r_dig_idx == '0) begin
                        n_state    = S_EMIT;
                        n_emit_idx = '0;
                    end else begin
                        n_dig_idx = r_dig_idx - 4'd1;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_block_end  = w_last;
                    n_stream_end = w_last && r_fin;
                    n_emit_idx   = r_emit_idx + 4'd1;
                    if (w_last) begin
                        n_state = S_IDLE;
                        n_block = '0;
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_block     <= '0;
            r_count     <= '0;
            r_rem       <= '0;
            r_step      <= '0;
            r_dig_idx   <= '0;
            r_ndig      <= '0;
            r_emit_idx  <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_block     <= n_block;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_step      <= n_step;
            r_dig_idx   <= n_dig_idx;
            r_ndig      <= n_ndig;
            r_emit_idx  <= n_emit_idx;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_block_end  <= n_block_end;
        r_stream_end <= n_stream_end;
    end

    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_buf[r_dig_idx] <= w_rem;
        end
        if (w_load) begin
            r_out_char <= char_of(r_buf[r_emit_idx]);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_block_end  = r_block_end;
    assign o_stream_end = r_stream_end;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < 6'(RADIX))
        else $error("partial remainder out of range");

    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit_idx < r_ndig))
        else $error("emit index past digit count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < COUNT_W'(FULL_BYTES)))
        else $error("byte count overflow while gathering");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_end) |-> o_block_end)
        else $error("stream end without block end");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && w_last) |=> (r_state == S_IDLE && o_out_valid))
        else $error("last character not loaded on leaving emit");

endmodule

### sv/b58enc_div_step.sv
module b58enc_div_step
    import b58enc_pkg::*;
(
    input  logic [DIGIT_W-1:0] i_rem,
    input  logic [BYTE_W-1:0]  i_byte,
    output logic [BYTE_W-1:0]  o_quot,
    output logic [DIGIT_W-1:0] o_rem
);

    logic [DIVIDEND_W-1:0] w_x;
    logic [PROD_W-1:0]     w_prod;
    logic [DIVIDEND_W-1:0] w_q58;
    logic [DIVIDEND_W-1:0] w_diff;

    assign w_x    = {i_rem, i_byte};
    assign w_prod = PROD_W'(w_x) * PROD_W'(RECIP);
    assign o_quot = w_prod[RECIP_SHIFT +: BYTE_W];

    // q * 58 = q * 64 - q * 4 - q * 2
    assign w_q58  = {o_quot, 6'b000000} - DIVIDEND_W'({o_quot, 2'b00})
                  - DIVIDEND_W'({o_quot, 1'b0});
    assign w_diff = w_x - w_q58;
    assign o_rem  = w_diff[DIGIT_W-1:0];

endmodule
